FILE: src/lzd_pkg.sv
package lzd_pkg;

    localparam int WINDOW_DEPTH = 4096;
    localparam int WIN_AW       = $clog2(WINDOW_DEPTH);
    localparam int CFG_AW       = 4;

    localparam logic [1:0] REG_RAW_SIZE    = 2'd0;
    localparam logic [1:0] REG_PACKED_SIZE = 2'd1;
    localparam logic [1:0] REG_CHUNK_COUNT = 2'd2;

    localparam logic [1:0] ST_BUSY = 2'd0;
    localparam logic [1:0] ST_OK   = 2'd1;
    localparam logic [1:0] ST_FAIL = 2'd2;

    typedef struct packed {
        logic [31:0] raw_size;
        logic [31:0] packed_size;
        logic [7:0]  chunk_count;
    } t_cfg;

endpackage

FILE: src/fixed_prefix_lz_byte_decompressor.sv
// Fixed prefix LZ decompressor, one packed byte per input word.
// Input channel: i_in_valid / o_in_stall with i_packed_byte, the stream
// bytes that follow the header. Output channel: o_out_valid / i_out_stall
// carrying up to eight decoded bytes (lowest lane first), a count, a
// run_last flag on the final word caused by an input byte, and
// finished/status on that final word.
// Every accepted byte gives at least one output word. A byte is decoded
// one bit or raw byte per cycle while no stalled receiver holds it; match
// bytes come from the history RAM, each read first and then written back;
// full words leave while decoding goes on. Registers: raw_size at 0x0,
// packed_size at 0x4, chunk_count at 0x8; the user must have them written
// over the APB port only while the block is idle, which the block does not
// enforce. Reset clears the decoder and expects the two filler bits first;
// the history RAM is not cleared. A stalled receiver holds the output word
// and pauses decoding when the next word is needed.
module fixed_prefix_lz_byte_decompressor import lzd_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [7:0]        i_packed_byte,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [63:0]       o_out_data,
    output logic [3:0]        o_out_count,
    output logic              o_run_last,
    output logic              o_finished,
    output logic [1:0]        o_status
);
    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.raw_size    <= 32'd1;
            r_cfg.packed_size <= 32'd1;
            r_cfg.chunk_count <= 8'd1;
        end else if (psel && penable && pwrite) begin
            case (paddr[3:2])
                REG_RAW_SIZE:    r_cfg.raw_size    <= pwdata;
                REG_PACKED_SIZE: r_cfg.packed_size <= pwdata;
                REG_CHUNK_COUNT: r_cfg.chunk_count <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_RAW_SIZE:    prdata = r_cfg.raw_size;
            REG_PACKED_SIZE: prdata = r_cfg.packed_size;
            REG_CHUNK_COUNT: prdata = {24'd0, r_cfg.chunk_count};
            default:         prdata = 32'd0;
        endcase
    end

    assign pready = 1'b1;

    lzd_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_packed_byte (i_packed_byte),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out_data    (o_out_data),
        .o_out_count   (o_out_count),
        .o_run_last    (o_run_last),
        .o_finished    (o_finished),
        .o_status      (o_status)
    );
endmodule

FILE: src/lzd_ram.sv
module lzd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

FILE: src/lzd_core.sv
module lzd_core import lzd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_packed_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [63:0] o_out_data,
    output logic [3:0]  o_out_count,
    output logic        o_run_last,
    output logic        o_finished,
    output logic [1:0]  o_status
);
    typedef enum logic [1:0] {S_WAIT, S_RUN, S_FLUSH} t_step;
    typedef enum logic [3:0] {
        PH_FILL_A, PH_FILL_B, PH_CMD, PH_LIT_BYTE, PH_LEN_CODE, PH_DIST_CODE,
        PH_DIST_BYTE, PH_RUN_BITS, PH_RUN_BYTES, PH_MV2_BYTE, PH_CND_BYTE,
        PH_CONT_BIT, PH_COPY, PH_DONE
    } t_phase;

    function automatic logic [4:0] dist_code(input logic [5:0] a);
        case (a)
            6'd6:  dist_code = 5'd1;
            6'd8:  dist_code = 5'd2;
            6'd9:  dist_code = 5'd3;
            6'd21: dist_code = 5'd4;
            6'd23: dist_code = 5'd5;
            6'd29: dist_code = 5'd6;
            6'd31: dist_code = 5'd7;
            6'd40: dist_code = 5'd8;
            6'd41: dist_code = 5'd9;
            6'd44: dist_code = 5'd10;
            6'd45: dist_code = 5'd11;
            6'd56: dist_code = 5'd12;
            6'd57: dist_code = 5'd13;
            6'd60: dist_code = 5'd14;
            6'd61: dist_code = 5'd15;
            default: dist_code = 5'd16;
        endcase
    endfunction

    t_step       r_st;
    t_phase      r_phase, n_phase;
    logic [7:0]  r_bitbuf, n_bitbuf;
    logic [3:0]  r_bits, n_bits;
    logic [5:0]  r_acc, n_acc;
    logic [8:0]  r_len, n_len;
    logic [12:0] r_dist, n_dist;
    logic [6:0]  r_run, n_run;
    logic [8:0]  r_left, n_left;
    logic        r_cwr, n_cwr;
    logic [31:0] r_prod, n_prod;
    logic [31:0] r_cons, n_cons;
    logic [7:0]  r_chunks, n_chunks;
    logic        r_failed, n_failed;
    logic        r_ended, n_ended;
    logic        r_have, n_have;
    logic [7:0]  r_byte;
    logic [63:0] r_pack;
    logic [3:0]  r_pcnt;

    logic        r_ovalid, r_olast, r_ofin;
    logic [63:0] r_odata;
    logic [3:0]  r_ocount;
    logic [1:0]  r_ostat;

    logic        step_end, emit_en, hold, out_free, rd_en, word_set;
    logic [7:0]  emit_byte;
    logic [WIN_AW-1:0] raddr;
    logic [7:0]  rdata;
    logic [31:0] src;

    assign out_free = !r_ovalid || !i_out_stall;

    always_comb begin
        logic       is_bit, is_byte, need, got, bitv, ok_copy;
        logic [7:0] by;
        logic [4:0] m;
        logic [6:0] rep;
        logic [5:0] a;
        n_phase = r_phase; n_bitbuf = r_bitbuf; n_bits = r_bits; n_acc = r_acc;
        n_len = r_len; n_dist = r_dist; n_run = r_run; n_left = r_left;
        n_cwr = r_cwr; n_prod = r_prod; n_cons = r_cons; n_chunks = r_chunks;
        n_failed = r_failed; n_ended = r_ended; n_have = r_have;
        step_end = 1'b0; emit_en = 1'b0; emit_byte = r_byte; rd_en = 1'b0;
        got = 1'b0; bitv = 1'b0; by = r_byte; m = 5'd0; rep = 7'd0; a = 6'd0;
        ok_copy = 1'b0;
        src = r_prod - {19'd0, r_dist};
        raddr = src[WIN_AW-1:0];
        is_bit = (r_phase == PH_FILL_A) || (r_phase == PH_FILL_B) ||
                 (r_phase == PH_CMD) || (r_phase == PH_LEN_CODE) ||
                 (r_phase == PH_DIST_CODE) || (r_phase == PH_RUN_BITS) ||
                 (r_phase == PH_CONT_BIT);
        is_byte = (r_phase == PH_LIT_BYTE) || (r_phase == PH_DIST_BYTE) ||
                  (r_phase == PH_RUN_BYTES) || (r_phase == PH_MV2_BYTE) ||
                  (r_phase == PH_CND_BYTE);
        need = is_byte || (is_bit && r_bits == 4'd0);
        if (r_st == S_RUN && !r_ended) begin
            if (need) begin
                if (r_cons >= i_cfg.packed_size) begin
                    n_failed = 1'b1; n_ended = 1'b1; n_phase = PH_DONE;
                end else if (!r_have) begin
                    step_end = 1'b1;
                end else begin
                    got = 1'b1; n_have = 1'b0; n_cons = r_cons + 32'd1;
                    if (is_bit) begin
                        bitv = r_byte[7]; n_bitbuf = {r_byte[6:0], 1'b0}; n_bits = 4'd7;
                    end
                end
            end else if (is_bit) begin
                got = 1'b1; bitv = r_bitbuf[7];
                n_bitbuf = {r_bitbuf[6:0], 1'b0}; n_bits = r_bits - 4'd1;
            end
            if (got || r_phase == PH_COPY) begin
                case (r_phase)
                    PH_FILL_A: n_phase = PH_FILL_B;
                    PH_CMD: begin
                        if (bitv) begin
                            n_acc = r_acc + 6'd1;
                            if (r_acc >= 6'd3) n_phase = PH_CND_BYTE;
                        end else if (r_acc == 6'd0) begin
                            if (r_prod < i_cfg.raw_size) n_phase = PH_LIT_BYTE;
                            else begin n_failed = 1'b1; n_ended = 1'b1; n_phase = PH_DONE; end
                        end else if (r_acc == 6'd1) begin
                            n_phase = PH_LEN_CODE; n_acc = 6'd1;
                        end else if (r_acc == 6'd2) begin
                            n_phase = PH_MV2_BYTE;
                        end else begin
                            n_len = 9'd3; n_phase = PH_DIST_CODE; n_acc = 6'd0;
                        end
                    end
                    PH_LEN_CODE: begin
                        a = {r_acc[4:0], bitv}; n_acc = a;
                        case (a)
                            6'd4:  begin n_len = 9'd4; n_phase = PH_DIST_CODE; n_acc = 6'd0; end
                            6'd6:  begin n_len = 9'd5; n_phase = PH_DIST_CODE; n_acc = 6'd0; end
                            6'd10: begin n_len = 9'd6; n_phase = PH_DIST_CODE; n_acc = 6'd0; end
                            6'd11: begin n_len = 9'd7; n_phase = PH_DIST_CODE; n_acc = 6'd0; end
                            6'd14: begin n_len = 9'd8; n_phase = PH_DIST_CODE; n_acc = 6'd0; end
                            6'd15: begin n_phase = PH_RUN_BITS; n_acc = 6'd1; end
                            default: begin
                                if (a >= 6'd8) begin
                                    n_failed = 1'b1; n_ended = 1'b1; n_phase = PH_DONE;
                                end
                            end
                        endcase
                    end
                    PH_DIST_CODE: begin
                        if (r_acc == 6'd0 && !bitv) begin
                            m = 5'd0;
                        end else begin
                            a = {r_acc[4:0], bitv}; n_acc = a; m = dist_code(a);
                        end
                        if (!m[4]) begin
                            n_dist = {1'b0, m[3:0], 8'd0}; n_phase = PH_DIST_BYTE;
                        end else if (a >= 6'd32) begin
                            n_failed = 1'b1; n_ended = 1'b1; n_phase = PH_DONE;
                        end
                    end
                    PH_DIST_BYTE, PH_MV2_BYTE: begin
                        if (r_phase == PH_MV2_BYTE) begin
                            n_len = 9'd2; n_dist = {5'd0, by} + 13'd1;
                        end else begin
                            n_dist = (r_dist | {5'd0, by}) + 13'd1;
                        end
                        ok_copy = ({19'd0, n_dist} <= r_prod) &&
                                  ({1'b0, r_prod} + {24'd0, n_len} <= {1'b0, i_cfg.raw_size});
                        if (ok_copy) begin
                            n_phase = PH_COPY; n_left = n_len; n_cwr = 1'b0;
                        end else begin
                            n_failed = 1'b1; n_ended = 1'b1; n_phase = PH_DONE;
                        end
                    end
                    PH_RUN_BITS: begin
                        a = {r_acc[4:0], bitv}; n_acc = a;
                        if (a >= 6'd16) begin
                            rep = {1'b0, 2'b00, a[3:0]} + 7'd3;
                            rep = {rep[4:0], 2'b00};
                            if ({1'b0, r_prod} + {26'd0, rep} > {1'b0, i_cfg.raw_size}) begin
                                n_failed = 1'b1; n_ended = 1'b1; n_phase = PH_DONE;
                            end else begin
                                n_run = rep; n_phase = PH_RUN_BYTES;
                            end
                        end
                    end
                    PH_CND_BYTE: begin
                        if (by != 8'd0) begin
                            n_len = {1'b0, by} + 9'd8; n_phase = PH_DIST_CODE; n_acc = 6'd0;
                        end else begin
                            n_chunks = r_chunks + 8'd1; n_phase = PH_CONT_BIT;
                        end
                    end
                    PH_COPY: begin
                        if (!r_cwr) begin
                            rd_en = 1'b1; n_cwr = 1'b1;
                        end else begin
                            emit_en = 1'b1; emit_byte = rdata; n_cwr = 1'b0;
                            n_left = r_left - 9'd1;
                        end
                    end
                    PH_LIT_BYTE, PH_RUN_BYTES: begin
                        emit_en = 1'b1;
                        if (r_phase == PH_RUN_BYTES && r_run != 7'd0) n_run = r_run - 7'd1;
                    end
                    default: ;
                endcase
                if (emit_en) n_prod = r_prod + 32'd1;
                if ((r_phase == PH_FILL_B) || (r_phase == PH_LIT_BYTE) ||
                    (r_phase == PH_RUN_BYTES && n_run == 7'd0) ||
                    (r_phase == PH_COPY && r_cwr && n_left == 9'd0) ||
                    (r_phase == PH_CONT_BIT && bitv)) begin
                    if (r_chunks >= i_cfg.chunk_count) begin
                        n_ended = 1'b1; n_phase = PH_DONE;
                        n_failed = !(n_prod == i_cfg.raw_size && r_chunks == i_cfg.chunk_count);
                    end else begin
                        n_phase = PH_CMD; n_acc = 6'd0;
                    end
                end else if (r_phase == PH_CONT_BIT) begin
                    n_ended = 1'b1; n_phase = PH_DONE;
                    n_failed = !(r_prod == i_cfg.raw_size && r_chunks == i_cfg.chunk_count);
                end
            end
        end
        hold = emit_en && r_pcnt == 4'd8 && !out_free;
        word_set = (r_st == S_RUN && !step_end && !hold && emit_en && r_pcnt == 4'd8) ||
                   (r_st == S_FLUSH && out_free);
    end

    lzd_ram #(.WIDTH(8), .DEPTH(WINDOW_DEPTH)) u_hist (
        .i_clk   (i_clk),
        .i_we    (emit_en && !hold),
        .i_waddr (r_prod[WIN_AW-1:0]),
        .i_wdata (emit_byte),
        .i_re    (rd_en),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_WAIT; r_phase <= PH_FILL_A; r_bitbuf <= '0; r_bits <= '0;
            r_acc <= '0; r_len <= '0; r_dist <= '0; r_run <= '0; r_left <= '0;
            r_cwr <= 1'b0; r_prod <= '0; r_cons <= '0; r_chunks <= '0;
            r_failed <= 1'b0; r_ended <= 1'b0; r_have <= 1'b0;
            r_pack <= '0; r_pcnt <= '0; r_ovalid <= 1'b0;
        end else begin
            r_ovalid <= word_set || (r_ovalid && i_out_stall);
            case (r_st)
                S_WAIT: begin
                    if (i_in_valid) begin
                        r_byte <= i_packed_byte;
                        if (r_ended) r_st <= S_FLUSH;
                        else begin r_have <= 1'b1; r_st <= S_RUN; end
                    end
                end
                S_RUN: begin
                    if (r_ended || step_end) begin
                        r_st <= S_FLUSH;
                    end else if (!hold) begin
                        r_phase <= n_phase; r_bitbuf <= n_bitbuf; r_bits <= n_bits;
                        r_acc <= n_acc; r_len <= n_len; r_dist <= n_dist; r_run <= n_run;
                        r_left <= n_left; r_cwr <= n_cwr; r_prod <= n_prod;
                        r_cons <= n_cons; r_chunks <= n_chunks; r_failed <= n_failed;
                        r_ended <= n_ended; r_have <= n_have;
                        if (emit_en) begin
                            if (r_pcnt == 4'd8) begin
                                r_odata <= r_pack; r_ocount <= 4'd8;
                                r_olast <= 1'b0; r_ofin <= 1'b0; r_ostat <= ST_BUSY;
                                r_pack <= {56'd0, emit_byte}; r_pcnt <= 4'd1;
                            end else begin
                                r_pack[8*r_pcnt[2:0] +: 8] <= emit_byte;
                                r_pcnt <= r_pcnt + 4'd1;
                            end
                        end
                    end
                end
                S_FLUSH: begin
                    if (out_free) begin
                        r_odata <= r_pack; r_ocount <= r_pcnt;
                        r_olast <= 1'b1; r_ofin <= r_ended;
                        r_ostat <= r_ended ? (r_failed ? ST_FAIL : ST_OK) : ST_BUSY;
                        r_pack <= '0; r_pcnt <= '0; r_st <= S_WAIT;
                    end
                end
                default: r_st <= S_WAIT;
            endcase
        end
    end

    assign o_in_stall  = (r_st != S_WAIT);
    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_odata;
    assign o_out_count = r_ocount;
    assign o_run_last  = r_olast;
    assign o_finished  = r_ofin;
    assign o_status    = r_ostat;

    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid |-> r_ocount <= 4'd8)
        else $error("word count above eight");
    a_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ended |-> r_phase == PH_DONE)
        else $error("ended outside done phase");
    a_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_failed |-> r_ended)
        else $error("failure without end");
    a_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == S_WAIT && i_in_valid && !r_ended) |=> (r_have && r_st == S_RUN))
        else $error("accepted byte lost");
endmodule

FILE: tb/fixed_prefix_lz_byte_decompressor_test.sv
module fixed_prefix_lz_byte_decompressor_test;
    import lzd_pkg::*;

    typedef enum logic [3:0] {
        P_FILL_A, P_FILL_B, P_CMD, P_LIT, P_LEN, P_DCODE, P_DBYTE,
        P_RUNBITS, P_RUNBYTES, P_MV2, P_CND, P_CONT, P_DONE
    } t_phase;

    typedef enum int {K_LIT, K_M2, K_M3, K_ML, K_RUN, K_LONG, K_CHUNK} t_cmd;

    typedef struct packed {
        logic [63:0] data;
        logic [3:0]  cnt;
        logic        last;
        logic        fin;
        logic [1:0]  st;
    } t_word;

    typedef struct {
        t_cmd kind;
        int   len;
        int   val;
        int   reps;
    } t_cmd_row;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [CFG_AW-1:0] paddr = '0;
    logic [31:0]       pwdata = '0;
    logic [31:0]       prdata;
    logic              pready;
    logic              i_in_valid = 1'b0;
    logic              o_in_stall;
    logic [7:0]        i_packed_byte = 8'h00;
    logic              o_out_valid;
    logic              i_out_stall = 1'b0;
    logic [63:0]       o_out_data;
    logic [3:0]        o_out_count;
    logic              o_run_last;
    logic              o_finished;
    logic [1:0]        o_status;

    fixed_prefix_lz_byte_decompressor DUT (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // decoder prediction
    logic [7:0]        win [WINDOW_DEPTH];
    logic [31:0]       raw_sz = 32'd1, pk_sz = 32'd1;
    logic [7:0]        chunk_n = 8'd1;
    t_phase            ph = P_FILL_A;
    logic [7:0]        bbuf = 8'h00, in_b = 8'h00, chunks = 8'h00;
    int unsigned       bleft = 0, acc = 0, mlen = 0, mdist = 0, runleft = 0;
    longint unsigned   produced = 0, consumed = 0;
    bit                failed = 0, ended = 0, have_in = 0;
    logic [7:0]        made [$];
    t_word             due_words [$];

    int                errors = 0;
    bit                calm = 0, hold_req = 0;
    int                hold_left = 0;

    // stream encoder
    logic [7:0]        stream [$];
    int                bit_at = 0, slots = 0;
    longint unsigned   enc_prod = 0;
    int                enc_chunks = 0;
    int                dcode [16] = '{0, 6, 8, 9, 21, 23, 29, 31, 40, 41, 44, 45, 56, 57, 60, 61};
    int                dlen  [16] = '{1, 3, 4, 4, 5, 5, 5, 5, 6, 6, 6, 6, 6, 6, 6, 6};

    t_cmd_row opening [17] = '{
        '{K_LIT, 1, 8'h00, 1},   '{K_LIT, 1, 8'hff, 1},   '{K_M2, 2, 1, 1},
        '{K_M3, 3, 2, 1},        '{K_ML, 4, 1, 1},        '{K_ML, 5, 3, 1},
        '{K_ML, 6, 4, 1},        '{K_ML, 7, 5, 1},        '{K_ML, 8, 256, 1},
        '{K_RUN, 12, 0, 1},      '{K_RUN, 72, 0, 1},      '{K_LONG, 9, 1, 1},
        '{K_M2, 2, 256, 1},      '{K_LONG, 263, 300, 16}, '{K_ML, 8, 4096, 1},
        '{K_M3, 3, 4096, 1},     '{K_CHUNK, 0, 1, 1}
    };

    task automatic report(string what, logic [63:0] exp_v, logic [63:0] got_v);
        $display("mismatch %s: expected %h, got %h", what, exp_v, got_v);
        errors++;
    endtask

    task automatic stop_decoding(bit ok);
        if (!ok) failed = 1;
        ended = 1;
        ph = P_DONE;
    endtask

    task automatic conclude();
        stop_decoding(produced == raw_sz && chunks == chunk_n);
    endtask

    task automatic take_byte(output int r, output logic [7:0] b);
        b = 8'h00;
        if (consumed >= pk_sz) begin
            stop_decoding(0);
            r = -1;
        end else if (!have_in) begin
            r = 0;
        end else begin
            b = in_b;
            have_in = 0;
            consumed++;
            r = 1;
        end
    endtask

    task automatic take_bit(output int r, output int unsigned bv);
        logic [7:0] b;
        bv = 0;
        r = 1;
        if (bleft == 0) begin
            take_byte(r, b);
            if (r > 0) begin
                bbuf = b;
                bleft = 8;
            end
        end
        if (r > 0) begin
            bv = bbuf[7];
            bbuf = bbuf << 1;
            bleft--;
        end
    endtask

    task automatic put_out(logic [7:0] v);
        win[produced % WINDOW_DEPTH] = v;
        made.push_back(v);
        produced++;
    endtask

    task automatic copy_back(int unsigned back, int unsigned len);
        if (len == 0 || back > produced || produced + len > raw_sz) begin
            stop_decoding(0);
        end else begin
            for (int i = 0; i < len; i++)
                put_out(win[(produced - back) % WINDOW_DEPTH]);
        end
    endtask

    task automatic next_command();
        if (chunks >= chunk_n) begin
            conclude();
        end else begin
            ph = P_CMD;
            acc = 0;
        end
    endtask

    function automatic int dist_high(int unsigned a);
        for (int m = 1; m < 16; m++)
            if (dcode[m] == a) return m;
        return -1;
    endfunction

    task automatic run_decoder();
        int r;
        int m;
        int unsigned bv, len;
        logic [7:0] b;
        forever begin
            case (ph)
                P_FILL_A, P_FILL_B: begin
                    take_bit(r, bv);
                    if (r <= 0) return;
                    if (ph == P_FILL_A) ph = P_FILL_B;
                    else next_command();
                end
                P_CMD: begin
                    take_bit(r, bv);
                    if (r <= 0) return;
                    if (bv) begin
                        acc++;
                        if (acc >= 4) ph = P_CND;
                    end else if (acc == 0) begin
                        if (produced < raw_sz) ph = P_LIT;
                        else stop_decoding(0);
                    end else if (acc == 1) begin
                        ph = P_LEN;
                    end else if (acc == 2) begin
                        ph = P_MV2;
                    end else begin
                        mlen = 3;
                        ph = P_DCODE;
                        acc = 0;
                    end
                end
                P_LIT: begin
                    take_byte(r, b);
                    if (r <= 0) return;
                    put_out(b);
                    next_command();
                end
                P_LEN: begin
                    take_bit(r, bv);
                    if (r <= 0) return;
                    acc = ((acc << 1) | bv) & 63;
                    case (acc)
                        4: len = 4;
                        6: len = 5;
                        10: len = 6;
                        11: len = 7;
                        14: len = 8;
                        15: len = 9;
                        default: len = 0;
                    endcase
                    if (len == 9) begin
                        ph = P_RUNBITS;
                        acc = 1;
                    end else if (len != 0) begin
                        mlen = len;
                        ph = P_DCODE;
                        acc = 0;
                    end else if (acc >= 8) begin
                        stop_decoding(0);
                    end
                end
                P_DCODE: begin
                    take_bit(r, bv);
                    if (r <= 0) return;
                    if (acc == 0 && !bv) begin
                        m = 0;
                    end else begin
                        acc = ((acc << 1) | bv) & 63;
                        m = dist_high(acc);
                    end
                    if (m >= 0) begin
                        mdist = m << 8;
                        ph = P_DBYTE;
                    end else if (acc >= 32) begin
                        stop_decoding(0);
                    end
                end
                P_DBYTE: begin
                    take_byte(r, b);
                    if (r <= 0) return;
                    mdist = (mdist | b) + 1;
                    copy_back(mdist, mlen);
                    if (!ended) next_command();
                end
                P_RUNBITS: begin
                    take_bit(r, bv);
                    if (r <= 0) return;
                    acc = ((acc << 1) | bv) & 63;
                    if (acc >= 16) begin
                        len = ((acc & 15) + 3) * 4;
                        if (produced + len > raw_sz) begin
                            stop_decoding(0);
                        end else begin
                            runleft = len;
                            ph = P_RUNBYTES;
                        end
                    end
                end
                P_RUNBYTES: begin
                    take_byte(r, b);
                    if (r <= 0) return;
                    put_out(b);
                    if (runleft > 0) runleft--;
                    if (runleft == 0) next_command();
                end
                P_MV2: begin
                    take_byte(r, b);
                    if (r <= 0) return;
                    mlen = 2;
                    mdist = b + 1;
                    copy_back(mdist, mlen);
                    if (!ended) next_command();
                end
                P_CND: begin
                    take_byte(r, b);
                    if (r <= 0) return;
                    if (b != 0) begin
                        mlen = b + 8;
                        ph = P_DCODE;
                        acc = 0;
                    end else begin
                        chunks = chunks + 8'd1;
                        ph = P_CONT;
                    end
                end
                P_CONT: begin
                    take_bit(r, bv);
                    if (r <= 0) return;
                    if (!bv) conclude();
                    else next_command();
                end
                default: return;
            endcase
            if (ended) return;
        end
    endtask

    task automatic decode_byte(logic [7:0] b);
        int n;
        t_word w;
        made.delete();
        if (!ended) begin
            in_b = b;
            have_in = 1;
            run_decoder();
            have_in = 0;
        end
        n = (made.size() == 0) ? 1 : (made.size() + 7) / 8;
        for (int k = 0; k < n; k++) begin
            w = '0;
            for (int j = 0; j < 8 && k * 8 + j < made.size(); j++) begin
                w.data[8*j +: 8] = made[k * 8 + j];
                w.cnt++;
            end
            w.last = (k == n - 1);
            w.fin = w.last && ended;
            w.st = !(w.last && ended) ? ST_BUSY : (failed ? ST_FAIL : ST_OK);
            due_words.push_back(w);
        end
    endtask

    // stream building
    task automatic pack_bit(int v);
        if (slots == 0) begin
            stream.push_back(8'h00);
            bit_at = stream.size() - 1;
            slots = 8;
        end
        slots--;
        if (v != 0) stream[bit_at] = stream[bit_at] | (8'h01 << slots);
    endtask

    task automatic pack_bits(int v, int n);
        for (int i = n - 1; i >= 0; i--) pack_bit((v >> i) & 1);
    endtask

    function automatic int usable_dist(int want);
        int d;
        d = want;
        if (d > enc_prod) d = enc_prod;
        if (d > WINDOW_DEPTH) d = WINDOW_DEPTH;
        if (d < 1) d = 1;
        return d;
    endfunction

    task automatic pack_dist(int want);
        int d;
        d = usable_dist(want);
        pack_bits(dcode[(d - 1) >> 8], dlen[(d - 1) >> 8]);
        stream.push_back(8'((d - 1) & 255));
    endtask

    task automatic pack_cmd(t_cmd kind, int len, int val);
        case (kind)
            K_LIT: begin
                pack_bit(0);
                stream.push_back(8'(val));
                enc_prod += 1;
            end
            K_M2: begin
                pack_bits(3'b110, 3);
                stream.push_back(8'(usable_dist(val > 256 ? 256 : val) - 1));
                enc_prod += 2;
            end
            K_M3: begin
                pack_bits(4'b1110, 4);
                pack_dist(val);
                enc_prod += 3;
            end
            K_ML: begin
                pack_bits(2'b10, 2);
                case (len)
                    4: pack_bits(2'b00, 2);
                    5: pack_bits(2'b10, 2);
                    6: pack_bits(3'b010, 3);
                    7: pack_bits(3'b011, 3);
                    default: pack_bits(3'b110, 3);
                endcase
                pack_dist(val);
                enc_prod += len;
            end
            K_RUN: begin
                pack_bits(5'b10111, 5);
                pack_bits(len / 4 - 3, 4);
                for (int i = 0; i < len; i++) stream.push_back(8'($urandom));
                enc_prod += len;
            end
            K_LONG: begin
                pack_bits(4'b1111, 4);
                stream.push_back(8'(len - 8));
                pack_dist(val);
                enc_prod += len;
            end
            default: begin
                pack_bits(4'b1111, 4);
                stream.push_back(8'h00);
                pack_bit(val);
                enc_chunks++;
            end
        endcase
    endtask

    task automatic random_cmd();
        int pick;
        int want;
        pick = $urandom_range(99);
        want = ($urandom_range(3) == 0) ? $urandom_range(1, WINDOW_DEPTH) : $urandom_range(1, 64);
        if (pick < 30) pack_cmd(K_LIT, 1, $urandom);
        else if (pick < 42) pack_cmd(K_M2, 2, want);
        else if (pick < 54) pack_cmd(K_M3, 3, want);
        else if (pick < 72) pack_cmd(K_ML, $urandom_range(4, 8), want);
        else if (pick < 82) pack_cmd(K_RUN, 4 * $urandom_range(3, 18), 0);
        else if (pick < 96 || enc_chunks > 20)
            pack_cmd(K_LONG, ($urandom_range(9) == 0) ? $urandom_range(9, 263)
                                                    : $urandom_range(9, 30), want);
        else pack_cmd(K_CHUNK, 0, 1);
    endtask

    task automatic reg_write(logic [1:0] idx, logic [31:0] v);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= CFG_AW'({idx, 2'b00});
        pwdata <= v;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_RAW_SIZE:    raw_sz = v;
            REG_PACKED_SIZE: pk_sz = v;
            default:         chunk_n = v[7:0];
        endcase
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (due_words.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic send_word(logic [7:0] b);
        while (!calm && $urandom_range(99) < 36) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_packed_byte <= b;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        decode_byte(b);
    endtask

    always @(posedge i_clk) begin
        t_word w;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (due_words.size() == 0) begin
                report("unexpected word", 64'd0, o_out_data);
            end else begin
                w = due_words.pop_front();
                if (o_out_data !== w.data) report("out_data", w.data, o_out_data);
                if (o_out_count !== w.cnt) report("out_count", w.cnt, o_out_count);
                if (o_run_last !== w.last) report("run_last", w.last, o_run_last);
                if (o_finished !== w.fin) report("finished", w.fin, o_finished);
                if (o_status !== w.st) report("status", w.st, o_status);
            end
        end
        if (hold_req) begin
            hold_left = 400;
            hold_req = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= !calm && ($urandom_range(99) < 36);
        end
    end

    initial begin
        #10_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        int end_mode;
        int end_at;
        int fin_at;
        pack_bits(0, 2);
        foreach (opening[r])
            for (int k = 0; k < opening[r].reps; k++)
                pack_cmd(opening[r].kind, opening[r].len,
                         (opening[r].kind == K_LONG && k > 0) ? $urandom_range(1, 300)
                                                             : opening[r].val);
        while (stream.size() < 420) random_cmd();
        fin_at = stream.size();
        pack_cmd(K_CHUNK, 0, 0);
        end_mode = $urandom_range(2);
        end_at = (end_mode == 0) ? fin_at : stream.size() - $urandom_range(2, 12);

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        reg_write(REG_RAW_SIZE, 32'hffff_ffff);
        reg_write(REG_PACKED_SIZE, 32'hffff_ffff);
        reg_write(REG_CHUNK_COUNT, 32'd255);

        for (int i = 0; i < stream.size(); i++) begin
            calm = (i >= 140 && i < 200);
            if (i == end_at) begin
                drain();
                if (end_mode == 0) begin
                    reg_write(REG_RAW_SIZE, produced[31:0]);
                    reg_write(REG_CHUNK_COUNT, {24'd0, chunks + 8'd1});
                    reg_write(REG_PACKED_SIZE, stream.size());
                end else if (end_mode == 1) begin
                    reg_write(REG_PACKED_SIZE, consumed[31:0]);
                end else begin
                    reg_write(REG_RAW_SIZE, produced[31:0]);
                end
            end else if (i % 110 == 0 && i > 0 && i < end_at) begin
                drain();
                reg_write(REG_RAW_SIZE, (i == 220) ? 32'hffff_ffff
                                                   : 32'(enc_prod) + $urandom_range(0, 999));
                reg_write(REG_PACKED_SIZE, (i == 330) ? 32'hffff_ffff
                                                      : stream.size() + $urandom_range(0, 99));
                reg_write(REG_CHUNK_COUNT, $urandom_range(enc_chunks, 255));
                if (i == 220) hold_req = 1;
            end
            send_word(stream[i]);
        end
        for (int i = 0; i < 4; i++) send_word(8'($urandom));

        i_in_valid <= 1'b0;
        while (due_words.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (due_words.size() != 0) report("words never came", due_words.size(), 64'd0);
        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
